@@ rtl/mired_to_rgb_with_brightness_macros.svh @@
// Assertion macros for the mired to RGB converter.
// Used by the top level; clock and reset are passed in by the caller.
`ifndef MIRED_TO_RGB_WITH_BRIGHTNESS_MACROS_SVH
`define MIRED_TO_RGB_WITH_BRIGHTNESS_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MTRGB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MTRGB_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MTRGB_ASSERT(lbl, clk, rst_n, prop, msg)
`define MTRGB_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

@@ rtl/mtrgb_pkg.sv @@
// Shared constants, reciprocals and the blackbody level table for the
// mired to RGB converter. No dependencies.
package mtrgb_pkg;

  localparam int unsigned MiredW   = 9;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ProdW    = 22;   // (500 - ct) * 4500 < 2^22
  localparam int unsigned QuotW    = 13;   // /347 result <= 6484
  localparam int unsigned SumW     = 14;   // quotient + 2000 <= 8484
  localparam int unsigned RowW     = 7;
  localparam int unsigned LevelW   = 16;   // level * brightness

  localparam logic [MiredW-1:0] MiredMax  = 9'd500;
  localparam logic [12:0]       Gain      = 13'd4500;
  localparam logic [10:0]       TempBase  = 11'd2000;
  localparam logic [RowW-1:0]   TempFirst = 7'd20;
  localparam logic [RowW-1:0]   RowLast   = 7'd64;

  // floor(p/347) = (p * Recip347) >> 31 for p < 2^22
  localparam logic [22:0] Recip347 = 23'd6188714;
  localparam int unsigned Shift347 = 31;
  // floor(u/100) = (u * Recip100) >> 20 for u < 2^14
  localparam logic [13:0] Recip100 = 14'd10486;
  localparam int unsigned Shift100 = 20;

  localparam int unsigned NumRows = 65;

  typedef struct packed {
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
  } rgb_t;

  localparam rgb_t Curve [NumRows] = '{
    '{8'd255,8'd137,8'd14 }, '{8'd255,8'd142,8'd27 }, '{8'd255,8'd146,8'd39 },
    '{8'd255,8'd151,8'd50 }, '{8'd255,8'd155,8'd61 }, '{8'd255,8'd159,8'd70 },
    '{8'd255,8'd163,8'd79 }, '{8'd255,8'd167,8'd87 }, '{8'd255,8'd170,8'd95 },
    '{8'd255,8'd174,8'd103}, '{8'd255,8'd177,8'd110}, '{8'd255,8'd180,8'd117},
    '{8'd255,8'd184,8'd123}, '{8'd255,8'd187,8'd129}, '{8'd255,8'd190,8'd135},
    '{8'd255,8'd193,8'd141}, '{8'd255,8'd195,8'd146}, '{8'd255,8'd198,8'd151},
    '{8'd255,8'd201,8'd157}, '{8'd255,8'd203,8'd161}, '{8'd255,8'd206,8'd166},
    '{8'd255,8'd208,8'd171}, '{8'd255,8'd211,8'd175}, '{8'd255,8'd213,8'd179},
    '{8'd255,8'd215,8'd183}, '{8'd255,8'd218,8'd187}, '{8'd255,8'd220,8'd191},
    '{8'd255,8'd222,8'd195}, '{8'd255,8'd224,8'd199}, '{8'd255,8'd226,8'd202},
    '{8'd255,8'd228,8'd206}, '{8'd255,8'd230,8'd209}, '{8'd255,8'd232,8'd213},
    '{8'd255,8'd234,8'd216}, '{8'd255,8'd236,8'd219}, '{8'd255,8'd237,8'd222},
    '{8'd255,8'd239,8'd225}, '{8'd255,8'd241,8'd228}, '{8'd255,8'd243,8'd231},
    '{8'd255,8'd244,8'd234}, '{8'd255,8'd246,8'd237}, '{8'd255,8'd248,8'd240},
    '{8'd255,8'd249,8'd242}, '{8'd255,8'd251,8'd245}, '{8'd255,8'd253,8'd248},
    '{8'd255,8'd254,8'd250}, '{8'd255,8'd255,8'd255}, '{8'd254,8'd249,8'd255},
    '{8'd250,8'd246,8'd255}, '{8'd246,8'd244,8'd255}, '{8'd243,8'd242,8'd255},
    '{8'd240,8'd240,8'd255}, '{8'd237,8'd239,8'd255}, '{8'd234,8'd237,8'd255},
    '{8'd232,8'd236,8'd255}, '{8'd230,8'd235,8'd255}, '{8'd228,8'd234,8'd255},
    '{8'd226,8'd233,8'd255}, '{8'd224,8'd232,8'd255}, '{8'd223,8'd231,8'd255},
    '{8'd221,8'd230,8'd255}, '{8'd220,8'd229,8'd255}, '{8'd218,8'd228,8'd255},
    '{8'd217,8'd227,8'd255}, '{8'd216,8'd227,8'd255}
  };

  // x / 255 for x < 65280
  function automatic logic [ByteW-1:0] div255(input logic [LevelW-1:0] x);
    logic [LevelW:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[LevelW-1:ByteW]};
    return s[LevelW-1:ByteW];
  endfunction

endpackage

@@ rtl/mtrgb_if.sv @@
// Valid/ready channel interfaces for the mired to RGB converter.
// Depends on mtrgb_pkg for field widths.
interface mtrgb_in_if;
  logic                             valid;
  logic                             ready;
  logic [mtrgb_pkg::MiredW-1:0]     color_temp_mired;
  logic [mtrgb_pkg::ByteW-1:0]      brightness;
  modport source (output valid, color_temp_mired, brightness, input ready);
  modport sink   (input valid, color_temp_mired, brightness, output ready);
endinterface

interface mtrgb_out_if;
  logic                        valid;
  logic                        ready;
  logic [mtrgb_pkg::ByteW-1:0] red;
  logic [mtrgb_pkg::ByteW-1:0] green;
  logic [mtrgb_pkg::ByteW-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

@@ rtl/mired_to_rgb_with_brightness.sv @@
// Channel   | dir | payload                         | transfer
// pix_i     | in  | color_temp_mired[9], brightness | valid & ready
// pix_o     | out | red, green, blue (8 bits each)  | valid & ready
//
// Six register stages: gain multiply, /347, +2000 and /100 to a table row,
// table read, brightness multiply, /255 into the output register.
// One transfer per cycle sustained while pix_o stays ready.
// Each stage holds while its successor is full and stalled; bubbles close up.
// rst_ni clears the valid bits only; payload registers are not reset.
// Depends on mtrgb_pkg, mtrgb_if.sv and the macros header.
`include "mired_to_rgb_with_brightness_macros.svh"

module mired_to_rgb_with_brightness (
  input  logic        clk_i,
  input  logic        rst_ni,
  mtrgb_in_if.sink    pix_i,
  mtrgb_out_if.source pix_o
);

  localparam int unsigned NStg = 6;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] en;

  // stage payloads
  logic [mtrgb_pkg::ProdW-1:0]  p1_q;
  logic [mtrgb_pkg::QuotW-1:0]  q2_q;
  logic [mtrgb_pkg::RowW-1:0]   row3_q;
  mtrgb_pkg::rgb_t              lvl4_q;
  logic [mtrgb_pkg::LevelW-1:0] pr5_q, pg5_q, pb5_q;
  logic [mtrgb_pkg::ByteW-1:0]  bri1_q, bri2_q, bri3_q, bri4_q;
  mtrgb_pkg::rgb_t              out6_q;

  // next values
  logic [mtrgb_pkg::MiredW-1:0] ct_sat;
  logic [mtrgb_pkg::MiredW-1:0] diff;
  logic [mtrgb_pkg::ProdW-1:0]  p1_d;
  logic [44:0]                  qprod;
  logic [mtrgb_pkg::QuotW-1:0]  q2_d;
  logic [mtrgb_pkg::SumW-1:0]   usum;
  logic [27:0]                  tprod;
  logic [mtrgb_pkg::RowW-1:0]   temp_idx;
  logic [mtrgb_pkg::RowW-1:0]   row_raw;
  logic [mtrgb_pkg::RowW-1:0]   row3_d;

  // stall chain from the output backwards
  always_comb begin
    en[NStg-1] = !v_q[NStg-1] || pix_o.ready;
    for (int i = NStg - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign pix_i.ready = en[0];

  always_comb begin
    ct_sat   = (pix_i.color_temp_mired > mtrgb_pkg::MiredMax) ? mtrgb_pkg::MiredMax
                                                               : pix_i.color_temp_mired;
    diff     = mtrgb_pkg::MiredMax - ct_sat;
    p1_d     = mtrgb_pkg::ProdW'(diff) * mtrgb_pkg::ProdW'(mtrgb_pkg::Gain);
    qprod    = 45'(p1_q) * 45'(mtrgb_pkg::Recip347);
    q2_d     = qprod[mtrgb_pkg::Shift347 +: mtrgb_pkg::QuotW];
    usum     = mtrgb_pkg::SumW'(q2_q) + mtrgb_pkg::SumW'(mtrgb_pkg::TempBase);
    tprod    = 28'(usum) * 28'(mtrgb_pkg::Recip100);
    temp_idx = tprod[mtrgb_pkg::Shift100 +: mtrgb_pkg::RowW];
    row_raw  = temp_idx - mtrgb_pkg::TempFirst;
    // wraps high below the first row, so the clamp covers both ends
    row3_d   = (row_raw > mtrgb_pkg::RowLast) ? mtrgb_pkg::RowLast : row_raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= pix_i.valid;
      for (int i = 1; i < NStg; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p1_q   <= p1_d;
      bri1_q <= pix_i.brightness;
    end
    if (en[1]) begin
      q2_q   <= q2_d;
      bri2_q <= bri1_q;
    end
    if (en[2]) begin
      row3_q <= row3_d;
      bri3_q <= bri2_q;
    end
    if (en[3]) begin
      lvl4_q <= mtrgb_pkg::Curve[row3_q];
      bri4_q <= bri3_q;
    end
    if (en[4]) begin
      pr5_q <= mtrgb_pkg::LevelW'(lvl4_q.red)   * mtrgb_pkg::LevelW'(bri4_q);
      pg5_q <= mtrgb_pkg::LevelW'(lvl4_q.green) * mtrgb_pkg::LevelW'(bri4_q);
      pb5_q <= mtrgb_pkg::LevelW'(lvl4_q.blue)  * mtrgb_pkg::LevelW'(bri4_q);
    end
    if (en[5]) begin
      out6_q.red   <= mtrgb_pkg::div255(pr5_q);
      out6_q.green <= mtrgb_pkg::div255(pg5_q);
      out6_q.blue  <= mtrgb_pkg::div255(pb5_q);
    end
  end

  assign pix_o.valid = v_q[NStg-1];
  assign pix_o.red   = out6_q.red;
  assign pix_o.green = out6_q.green;
  assign pix_o.blue  = out6_q.blue;

  `MTRGB_ASSERT_NEXT(a_in_enters, clk_i, rst_ni, pix_i.valid && pix_i.ready, v_q[0], "accepted item did not enter stage one")
  `MTRGB_ASSERT_NEXT(a_mult_holds, clk_i, rst_ni, v_q[4] && !en[4], v_q[4] && $stable(pr5_q), "stalled product stage lost its item")
  `MTRGB_ASSERT(a_row_range, clk_i, rst_ni, v_q[2] |-> (row3_q <= mtrgb_pkg::RowLast), "table row out of range")

endmodule

@@ verif/tb.sv @@
// Self-checking bench for mired_to_rgb_with_brightness: streams pixels through
// the valid/ready channels under several flow-control patterns and checks each RGB transfer.
// Depends on mtrgb_pkg and the channel interfaces in mtrgb_if.sv.
module tb;

  localparam int unsigned MiredW = mtrgb_pkg::MiredW;
  localparam int unsigned ByteW  = mtrgb_pkg::ByteW;

  typedef mtrgb_pkg::rgb_t rgb_t;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SRC_GAPS,
    FLOW_SNK_STALLS,
    FLOW_BOTH
  } flow_e;

  typedef struct packed {
    logic [MiredW-1:0] mired;
    logic [ByteW-1:0]  bri;
  } pix_req_t;

  localparam int unsigned MIRED_CAP      = 500;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned PHASE_ITEMS    = 180;

  // Blackbody levels per temperature index 20..84
  localparam rgb_t BLACKBODY [65] = '{
    '{255,137, 14}, '{255,142, 27}, '{255,146, 39}, '{255,151, 50}, '{255,155, 61},
    '{255,159, 70}, '{255,163, 79}, '{255,167, 87}, '{255,170, 95}, '{255,174,103},
    '{255,177,110}, '{255,180,117}, '{255,184,123}, '{255,187,129}, '{255,190,135},
    '{255,193,141}, '{255,195,146}, '{255,198,151}, '{255,201,157}, '{255,203,161},
    '{255,206,166}, '{255,208,171}, '{255,211,175}, '{255,213,179}, '{255,215,183},
    '{255,218,187}, '{255,220,191}, '{255,222,195}, '{255,224,199}, '{255,226,202},
    '{255,228,206}, '{255,230,209}, '{255,232,213}, '{255,234,216}, '{255,236,219},
    '{255,237,222}, '{255,239,225}, '{255,241,228}, '{255,243,231}, '{255,244,234},
    '{255,246,237}, '{255,248,240}, '{255,249,242}, '{255,251,245}, '{255,253,248},
    '{255,254,250}, '{255,255,255}, '{254,249,255}, '{250,246,255}, '{246,244,255},
    '{243,242,255}, '{240,240,255}, '{237,239,255}, '{234,237,255}, '{232,236,255},
    '{230,235,255}, '{228,234,255}, '{226,233,255}, '{224,232,255}, '{223,231,255},
    '{221,230,255}, '{220,229,255}, '{218,228,255}, '{217,227,255}, '{216,227,255}
  };

  logic clk_i;
  logic rst_ni;

  mtrgb_in_if  pix_in ();
  mtrgb_out_if pix_out ();

  mired_to_rgb_with_brightness i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_in),
    .pix_o  (pix_out)
  );

  pix_req_t pix_backlog[$];
  rgb_t     rgb_due[$];
  flow_e    flow;
  int unsigned fail_cnt    = 0;
  int unsigned pix_sent    = 0;
  int unsigned rgb_seen    = 0;
  int unsigned sat_cnt     = 0;
  int unsigned dark_cnt    = 0;
  int unsigned idle_cycles = 0;

  function automatic logic [ByteW-1:0] dim(input logic [ByteW-1:0] lvl,
                                          input logic [ByteW-1:0] bri);
    int unsigned prod;
    prod = int'(lvl) * int'(bri);
    return ByteW'(prod / 255);
  endfunction

  function automatic rgb_t mired_to_rgb(input logic [MiredW-1:0] mired,
                                        input logic [ByteW-1:0]  bri);
    int unsigned ct;
    int unsigned temp_idx;
    int unsigned row;
    rgb_t        lvl;
    rgb_t        px;
    ct = (mired > MIRED_CAP) ? MIRED_CAP : int'(mired);
    temp_idx = (((MIRED_CAP - ct) * 4500) / 347 + 2000) / 100;
    row = temp_idx - 20;
    if (row > 64) row = 64;
    lvl = BLACKBODY[row];
    px.red   = dim(lvl.red, bri);
    px.green = dim(lvl.green, bri);
    px.blue  = dim(lvl.blue, bri);
    return px;
  endfunction

  function automatic logic src_idles(input flow_e f);
    if (f == FLOW_SRC_GAPS) return $urandom_range(99) < 66;
    if (f == FLOW_BOTH)     return $urandom_range(99) < 12;
    return 1'b0;
  endfunction

  function automatic logic snk_stalls(input flow_e f);
    if (f == FLOW_SNK_STALLS) return $urandom_range(99) < 66;
    if (f == FLOW_BOTH)       return $urandom_range(99) < 12;
    return 1'b0;
  endfunction

  // Random pixel, weighted towards saturation, the knee, the range ends and the brightness ends
  function automatic pix_req_t rand_pix();
    pix_req_t p;
    case ($urandom_range(9))
      0:       p.mired = MiredW'($urandom_range(511, 501));
      1:       p.mired = MiredW'($urandom_range(150, 128));
      2:       p.mired = $urandom_range(1) ? MiredW'(0) : MiredW'(500);
      default: p.mired = MiredW'($urandom_range(511));
    endcase
    case ($urandom_range(7))
      0:       p.bri = '0;
      1:       p.bri = '1;
      default: p.bri = ByteW'($urandom_range(255));
    endcase
    return p;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Source side: hold each pixel until transferred, then take the next one
  always @(posedge clk_i or negedge rst_ni) begin
    logic sent;
    pix_req_t nxt;
    if (!rst_ni) begin
      pix_in.valid            <= 1'b0;
      pix_in.color_temp_mired <= '0;
      pix_in.brightness       <= '0;
    end else begin
      sent = pix_in.valid && pix_in.ready;
      if (sent) begin
        rgb_due.push_back(mired_to_rgb(pix_in.color_temp_mired, pix_in.brightness));
        pix_sent++;
        if (pix_in.color_temp_mired > MIRED_CAP) sat_cnt++;
        if (pix_in.brightness == '0) dark_cnt++;
      end
      if (!pix_in.valid || sent) begin
        if (pix_backlog.size() != 0 && !src_idles(flow)) begin
          nxt = pix_backlog.pop_front();
          pix_in.valid            <= 1'b1;
          pix_in.color_temp_mired <= nxt.mired;
          pix_in.brightness       <= nxt.bri;
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  // Sink side: random back-pressure and in-order check of each RGB transfer
  always @(posedge clk_i or negedge rst_ni) begin
    rgb_t want;
    if (!rst_ni) begin
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= !snk_stalls(flow);
      if (pix_out.valid && pix_out.ready) begin
        rgb_seen++;
        if (rgb_due.size() == 0) begin
          $error("unexpected RGB transfer: red %0d green %0d blue %0d",
                 pix_out.red, pix_out.green, pix_out.blue);
          fail_cnt++;
        end else begin
          want = rgb_due.pop_front();
          if (pix_out.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, pix_out.red);
            fail_cnt++;
          end
          if (pix_out.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, pix_out.green);
            fail_cnt++;
          end
          if (pix_out.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, pix_out.blue);
            fail_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic queue_pix(input int unsigned mired, input int unsigned bri);
    pix_req_t p;
    p.mired = MiredW'(mired);
    p.bri   = ByteW'(bri);
    pix_backlog.push_back(p);
  endtask

  // Sender holds off until the pipeline has fully emptied
  task automatic drain();
    while (pix_backlog.size() != 0 || pix_in.valid) @(negedge clk_i);
    while (rgb_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_phase(input flow_e f, input int unsigned n);
    @(negedge clk_i);
    flow = f;
    repeat (n) pix_backlog.push_back(rand_pix());
    drain();
  endtask

  initial begin
    flow   = FLOW_FREE;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: range ends, saturation, both sides of the knee, brightness ends
    @(negedge clk_i);
    queue_pix(0, 255);
    queue_pix(0, 0);
    queue_pix(500, 255);
    queue_pix(501, 255);
    queue_pix(511, 255);
    queue_pix(511, 1);
    queue_pix(140, 255);  // index 66, green clamped at the knee
    queue_pix(146, 255);
    queue_pix(131, 255);
    queue_pix(140, 128);
    queue_pix(255, 0);
    queue_pix(256, 254);
    queue_pix(1, 1);
    queue_pix(499, 127);
    queue_pix(300, 200);
    queue_pix(420, 85);
    drain();

    run_phase(FLOW_FREE, PHASE_ITEMS);
    run_phase(FLOW_SRC_GAPS, PHASE_ITEMS);
    run_phase(FLOW_SNK_STALLS, PHASE_ITEMS);
    run_phase(FLOW_BOTH, PHASE_ITEMS);
    run_phase(FLOW_FREE, PHASE_ITEMS);

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (rgb_due.size() != 0) begin
      $error("%0d RGB results never arrived", rgb_due.size());
    end

    $display("%0d pixels in, %0d RGB out, over free-flow, gapped and stalled phases",
             pix_sent, rgb_seen);
    $display("%0d with mired saturated, %0d at zero brightness", sat_cnt, dark_cnt);
    if (fail_cnt == 0 && rgb_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
